@@ rtl/tcgw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_pkg
// Shared types and constants for the text console glyph writer: panel
// commands, word kinds, control codes, register indexes and the
// controller/datapath interface.
// ----------------------------------------------------------------------------
package tcgw_pkg;

    // Panel geometry and glyph cell size
    localparam int unsigned SHORT_SIDE = 128;
    localparam int unsigned LONG_SIDE  = 160;
    localparam int unsigned GLYPH_SIZE = 8;

    // Stream widths
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned KIND_W     = 2;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_ORIENT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TAB    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INK    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PAPER  = 3'd5;

    localparam logic [1:0]  RST_ORIENT = 2'd0;
    localparam logic [7:0]  RST_WIDTH  = 8'd128;
    localparam logic [7:0]  RST_HEIGHT = 8'd160;
    localparam logic [5:0]  RST_TAB    = 6'd4;
    localparam logic [15:0] RST_INK    = 16'd2016;
    localparam logic [15:0] RST_PAPER  = 16'd0;

    // Orientation codes
    localparam logic [1:0] ORIENT_PORTRAIT      = 2'd0;
    localparam logic [1:0] ORIENT_PORTRAIT_180  = 2'd1;
    localparam logic [1:0] ORIENT_LANDSCAPE     = 2'd2;
    localparam logic [1:0] ORIENT_LANDSCAPE_180 = 2'd3;

    // Panel commands
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    // Output word kinds
    localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;

    // Control codes
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_VT  = 8'd11;
    localparam logic [7:0] CH_FF  = 8'd12;
    localparam logic [7:0] CH_CR  = 8'd13;

    // Word positions within one drawn cell
    localparam logic [5:0] W_CASET     = 6'd0;
    localparam logic [5:0] W_COLS      = 6'd1;
    localparam logic [5:0] W_RASET     = 6'd2;
    localparam logic [5:0] W_ROW_START = 6'd3;
    localparam logic [5:0] W_ROW_END   = 6'd4;
    localparam logic [5:0] W_RAMWR     = 6'd5;
    localparam logic [5:0] W_PIX_FIRST = 6'd6;
    localparam logic [5:0] W_LAST      = 6'd37;

    // Linear cursor and divider sizing
    localparam int unsigned LIN_W     = 11;
    localparam int unsigned DIVISOR_W = 6;
    localparam int unsigned DIV_STEPS = LIN_W;

    typedef enum logic {
        DIV_SEL_LIN,
        DIV_SEL_TAB
    } tcgw_div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIN,
        ST_DIV_LIN,
        ST_WAIT_LIN,
        ST_DECODE,
        ST_DIV_TW,
        ST_WAIT_TW,
        ST_DIV_TAB,
        ST_WAIT_TAB,
        ST_WRAP,
        ST_DIV_FIN,
        ST_WAIT_FIN,
        ST_EMIT
    } tcgw_state_t;

    typedef struct packed {
        logic          load;
        logic          lin_calc;
        logic          div_start;
        tcgw_div_sel_t div_sel;
        logic          capture_pos;
        logic          decode;
        logic          tab_add;
        logic          tab_fix;
        logic          wrap;
        logic          cursor_write;
        logic          emit;
    } tcgw_cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_tab;
        logic draw;
        logic out_free;
        logic emit_last;
    } tcgw_status_t;

endpackage

@@ rtl/tcgw_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_divider
// Restoring divider, one quotient bit per cycle. Gives quotient and
// remainder of an 11-bit dividend by a nonzero 6-bit divisor.
// ----------------------------------------------------------------------------
module tcgw_divider
    import tcgw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [LIN_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic [LIN_W-1:0]     quotient,
    output logic [DIVISOR_W-1:0] remainder,
    output logic                 done
);

    logic [LIN_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [3:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;
    logic [DIVISOR_W-1:0] rem_next;

    // Shift in the next dividend bit and try to subtract
    always_comb begin
        trial    = {rem_reg, quo_reg[LIN_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    // Control: busy flag, step count and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands and partial results
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[LIN_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ rtl/tcgw_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_datapath
// Configuration registers, cursor, linear cursor arithmetic with the shared
// divider, window mapping and the registered output word.
// ----------------------------------------------------------------------------
module tcgw_datapath
    import tcgw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input item
    input  logic [IN_DATA_W-1:0]  in_data,
    // Controller link
    input  tcgw_cmd_t             cmd,
    output tcgw_status_t          status,
    // Output word
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [KIND_W-1:0]     out_kind,
    output logic                  out_last
);

    // Configuration registers
    logic [1:0]  orient_reg;
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [5:0]  tab_reg;
    logic [15:0] ink_reg;
    logic [15:0] paper_reg;

    // Cursor and item state
    logic [4:0]       row_reg;
    logic [4:0]       col_reg;
    logic [LIN_W-1:0] lin_reg;
    logic [LIN_W-1:0] q0_reg;
    logic [4:0]       r0_reg;
    logic [7:0]       code_reg;
    logic [63:0]      glyph_reg;
    logic             draw_reg;
    logic [4:0]       drow_reg;
    logic [4:0]       dcol_reg;
    logic [5:0]       idx_reg;

    // Output register
    logic                  ovalid_reg;
    logic [OUT_DATA_W-1:0] odata_reg;
    logic [KIND_W-1:0]     okind_reg;
    logic                  olast_reg;

    // Effective geometry
    logic [4:0]           cols;
    logic [4:0]           rows;
    logic [DIVISOR_W-1:0] tw;
    logic [9:0]           cells;

    // Divider link
    logic [LIN_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [LIN_W-1:0]     div_quo;
    logic [DIVISOR_W-1:0] div_rem;
    logic                 div_done;

    // Decode results
    logic [LIN_W-1:0] lin_dec;
    logic             draw_dec;
    logic [4:0]       dcol_dec;
    logic [4:0]       r0_dec;

    // Window and word generation
    logic [15:0] x1, x2, y1, y2, a1, packed_w, wy1, wy2;
    logic [5:0]  pix_off;
    logic [7:0]  pix_bits;
    logic [1:0]  pix_pair;
    logic        b0, b1;
    logic [OUT_DATA_W-1:0] word_data;
    logic [KIND_W-1:0]     word_kind;

    // Treat empty grids and zero tab spacing as one
    always_comb begin
        cols  = (width_reg[7:3] == 5'd0) ? 5'd1 : width_reg[7:3];
        rows  = (height_reg[7:3] == 5'd0) ? 5'd1 : height_reg[7:3];
        tw    = (tab_reg == 6'd0) ? 6'd1 : tab_reg;
        cells = {5'd0, cols} * {5'd0, rows};
    end

    // Divider operand select
    always_comb begin
        if (cmd.div_sel == DIV_SEL_TAB) begin
            div_dividend = {6'd0, r0_reg};
            div_divisor  = tw;
        end else begin
            div_dividend = lin_reg;
            div_divisor  = {1'b0, cols};
        end
    end

    tcgw_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg <= RST_ORIENT;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            tab_reg    <= RST_TAB;
            ink_reg    <= RST_INK;
            paper_reg  <= RST_PAPER;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ORIENT: orient_reg <= cfg_wdata[1:0];
                REG_WIDTH:  width_reg  <= cfg_wdata[7:0];
                REG_HEIGHT: height_reg <= cfg_wdata[7:0];
                REG_TAB:    tab_reg    <= cfg_wdata[5:0];
                REG_INK:    ink_reg    <= cfg_wdata;
                REG_PAPER:  paper_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Cursor moves for each code; draw position for backspace and printables
    always_comb begin
        lin_dec  = lin_reg;
        draw_dec = 1'b0;
        r0_dec   = r0_reg - 5'd1;
        dcol_dec = r0_reg;
        if (code_reg[7:5] != 3'd0) begin
            lin_dec  = lin_reg + 11'd1;
            draw_dec = (q0_reg < {6'd0, height_reg[7:3]}) && (r0_reg < width_reg[7:3]);
        end else begin
            unique case (code_reg)
                CH_BS: begin
                    if (r0_reg != 5'd0) begin
                        lin_dec  = lin_reg - 11'd1;
                        dcol_dec = r0_dec;
                        draw_dec = (q0_reg < {6'd0, height_reg[7:3]}) &&
                                   (r0_dec < width_reg[7:3]);
                    end
                end
                CH_FF:   lin_dec = '0;
                CH_LF:   lin_dec = lin_reg + {6'd0, cols} - {6'd0, r0_reg};
                CH_CR:   lin_dec = lin_reg - {6'd0, r0_reg};
                CH_VT:   lin_dec = lin_reg + {6'd0, cols};
                default: lin_dec = lin_reg;
            endcase
        end
    end

    // Item, cursor and linear cursor registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            draw_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            if (cmd.load) begin
                code_reg  <= in_data[7:0];
                glyph_reg <= in_data[IN_DATA_W-1:8];
                draw_reg  <= 1'b0;
                idx_reg   <= '0;
            end
            if (cmd.lin_calc) begin
                lin_reg <= ({6'd0, row_reg} * {6'd0, cols}) + {6'd0, col_reg};
            end
            if (cmd.capture_pos) begin
                q0_reg <= div_quo;
                r0_reg <= div_rem[4:0];
            end
            if (cmd.decode) begin
                lin_reg  <= lin_dec;
                draw_reg <= draw_dec;
                drow_reg <= q0_reg[4:0];
                dcol_reg <= dcol_dec;
            end
            if (cmd.tab_add) begin
                lin_reg <= lin_reg + {5'd0, tw} - {5'd0, div_rem};
            end
            if (cmd.tab_fix && (div_rem < tw)) begin
                lin_reg <= lin_reg - {5'd0, div_rem};
            end
            if (cmd.wrap && (lin_reg >= {1'b0, cells})) begin
                lin_reg <= '0;
            end
            if (cmd.cursor_write) begin
                row_reg <= div_quo[4:0];
                col_reg <= div_rem[4:0];
            end
            if (cmd.emit) begin
                idx_reg <= idx_reg + 6'd1;
            end
        end
    end

    // Cell corners in logical pixels
    always_comb begin
        x1 = {8'd0, dcol_reg, 3'd0};
        x2 = x1 + 16'(GLYPH_SIZE - 1);
        y1 = {8'd0, drow_reg, 3'd0};
        y2 = y1 + 16'(GLYPH_SIZE - 1);
    end

    // Map the window to panel coordinates, all modulo 2^16
    always_comb begin
        a1       = '0;
        packed_w = {x2[7:0], x1[7:0]};
        wy1      = y1;
        wy2      = y2;
        unique case (orient_reg)
            ORIENT_PORTRAIT_180: begin
                a1       = 16'(SHORT_SIDE - 1) - x1;
                packed_w = {a1[7:0], 8'd0} + (16'(SHORT_SIDE - 1) - x2);
                wy1      = 16'(LONG_SIDE - 1) - y2;
                wy2      = 16'(LONG_SIDE - 1) - y1;
            end
            ORIENT_LANDSCAPE: begin
                a1       = 16'(SHORT_SIDE - 1) - y1;
                packed_w = {a1[7:0], 8'd0} + (16'(SHORT_SIDE - 1) - y2);
                wy1      = x1;
                wy2      = x2;
            end
            ORIENT_LANDSCAPE_180: begin
                packed_w = {y2[7:0], y1[7:0]};
                wy1      = 16'(LONG_SIDE - 1) - x2;
                wy2      = 16'(LONG_SIDE - 1) - x1;
            end
            default: begin
                packed_w = {x2[7:0], x1[7:0]};
            end
        endcase
    end

    // Pick the pixel pair: row from the upper offset bits, pair from the lower
    always_comb begin
        pix_off  = idx_reg - W_PIX_FIRST;
        pix_bits = glyph_reg[{pix_off[4:2], 3'b000} +: 8];
        pix_pair = pix_off[1:0];
        b0       = pix_bits[{~pix_pair, 1'b1}];
        b1       = pix_bits[{~pix_pair, 1'b0}];
    end

    // Word for the current position in the cell sequence
    always_comb begin
        unique case (idx_reg)
            W_CASET: begin
                word_kind = KIND_CMD;
                word_data = {24'd0, CMD_CASET};
            end
            W_COLS: begin
                word_kind = KIND_DATA;
                word_data = {16'd0, packed_w};
            end
            W_RASET: begin
                word_kind = KIND_CMD;
                word_data = {24'd0, CMD_RASET};
            end
            W_ROW_START: begin
                word_kind = KIND_DATA;
                word_data = {16'd0, wy1 + 16'd2};
            end
            W_ROW_END: begin
                word_kind = KIND_DATA;
                word_data = {16'd0, wy2 + 16'd2};
            end
            W_RAMWR: begin
                word_kind = KIND_CMD;
                word_data = {24'd0, CMD_RAMWR};
            end
            default: begin
                word_kind = KIND_PIXEL;
                word_data = {b0 ? ink_reg : paper_reg, b1 ? ink_reg : paper_reg};
            end
        endcase
    end

    // Output register: load on emit, drop once the word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            odata_reg <= word_data;
            okind_reg <= word_kind;
            olast_reg <= (idx_reg == W_LAST);
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_kind  = okind_reg;
    assign out_last  = olast_reg;

    // Status back to the controller
    always_comb begin
        status.div_done  = div_done;
        status.is_tab    = (code_reg == CH_TAB);
        status.draw      = draw_reg;
        status.out_free  = !ovalid_reg || out_ready;
        status.emit_last = (idx_reg == W_LAST);
    end

endmodule

@@ rtl/tcgw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_ctrl
// Sequencer for one item: cursor position, code decode, tab steps, wrap,
// cursor write-back and the drawn cell's word sequence.
// ----------------------------------------------------------------------------
module tcgw_ctrl
    import tcgw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  tcgw_status_t status,
    output tcgw_cmd_t    cmd
);

    tcgw_state_t state_reg;
    tcgw_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_LIN;
            ST_LIN:      state_next = ST_DIV_LIN;
            ST_DIV_LIN:  state_next = ST_WAIT_LIN;
            ST_WAIT_LIN: if (status.div_done) state_next = ST_DECODE;
            ST_DECODE:   state_next = status.is_tab ? ST_DIV_TW : ST_WRAP;
            ST_DIV_TW:   state_next = ST_WAIT_TW;
            ST_WAIT_TW:  if (status.div_done) state_next = ST_DIV_TAB;
            ST_DIV_TAB:  state_next = ST_WAIT_TAB;
            ST_WAIT_TAB: if (status.div_done) state_next = ST_WRAP;
            ST_WRAP:     state_next = ST_DIV_FIN;
            ST_DIV_FIN:  state_next = ST_WAIT_FIN;
            ST_WAIT_FIN: begin
                if (status.div_done) begin
                    state_next = status.draw ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.out_free && status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_LIN:      cmd.lin_calc = 1'b1;
            ST_DIV_LIN:  cmd.div_start = 1'b1;
            ST_WAIT_LIN: cmd.capture_pos = status.div_done;
            ST_DECODE:   cmd.decode = 1'b1;
            ST_DIV_TW: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_TAB;
            end
            ST_WAIT_TW:  cmd.tab_add = status.div_done;
            ST_DIV_TAB:  cmd.div_start = 1'b1;
            ST_WAIT_TAB: cmd.tab_fix = status.div_done;
            ST_WRAP:     cmd.wrap = 1'b1;
            ST_DIV_FIN:  cmd.div_start = 1'b1;
            ST_WAIT_FIN: cmd.cursor_write = status.div_done;
            ST_EMIT:     cmd.emit = status.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

@@ rtl/text_console_glyph_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_writer
// Text console: keeps a cursor over an 8x8 cell grid, moves it on control
// codes and draws printable glyphs as panel window and pixel-pair words.
// ----------------------------------------------------------------------------
// Cursor update: each cursor divide runs on the shared one-bit-a-cycle
//   divider; an item needs 2 divides (4 for tab) between the input
//   transfer and the cursor write-back.
// A drawn cell then sends 38 words, one per cycle while m_tready is high.
// One item at a time: the next is accepted once the last cell word is loaded.
// Reset: aresetn (synchronous) loads register defaults, homes the cursor and
//   empties the output register.
module text_console_glyph_writer
    import tcgw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] char_code, [71:8] glyph_rows
    // Output words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] word_value
    output logic [KIND_W-1:0]     m_tuser,   // [1:0] word_kind
    output logic                  m_tlast    // last_word
);

    tcgw_cmd_t    cmd;
    tcgw_status_t status;

    tcgw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcgw_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

    // A new item only starts once the previous cell's last word is in the output register
    a_accept_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tvalid) |-> m_tlast)
        else $error("item accepted while a cell sequence is unfinished");

    // Every cell sequence ends on a pixel pair
    a_last_is_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_PIXEL))
        else $error("last word of a cell is not a pixel pair");

    // Words are loaded only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("output word overwritten before transfer");

    // Divider never reports done right after a start
    a_div_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !status.div_done)
        else $error("divider done one cycle after start");

endmodule

@@ tb/text_console_glyph_writer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_writer_checker
// Passive scoreboard for the text console glyph writer. It mirrors the
// configuration writes and the text cursor, and turns every input transfer
// into the panel words the block should send. Each output transfer is
// compared field by field with the oldest pending word.
// ----------------------------------------------------------------------------
module text_console_glyph_writer_checker
    import tcgw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] char_code, [71:8] glyph_rows
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] word_value
    input  logic [KIND_W-1:0]     m_tuser,   // [1:0] word_kind
    input  logic                  m_tlast,   // last_word
    output int                    fail_count,
    output int                    pending
);

    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [OUT_DATA_W-1:0] value;
        logic                  last;
    } panel_word_t;

    panel_word_t expected_words[$];

    // Mirrored registers and cursor
    logic [1:0]  orient_reg;
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [5:0]  tab_reg;
    logic [15:0] ink_reg;
    logic [15:0] paper_reg;
    logic [4:0]  cursor_row;
    logic [4:0]  cursor_col;

    // Queue the window setup and pixel pairs of one drawn cell
    task automatic queue_cell_words(input int unsigned row, input int unsigned col,
                                    input logic [63:0] glyph);
        logic [31:0] x1, y1, x2, y2, a1, a2, col_word;
        logic [15:0] c0, c1;
        int unsigned r, p;
        // Cells past the right or bottom edge are skipped
        if (row * GLYPH_SIZE + GLYPH_SIZE > height_reg) return;
        if (col * GLYPH_SIZE + GLYPH_SIZE > width_reg) return;
        x1 = col * GLYPH_SIZE;
        y1 = row * GLYPH_SIZE;
        x2 = x1 + GLYPH_SIZE - 1;
        y2 = y1 + GLYPH_SIZE - 1;
        case (orient_reg)
            ORIENT_PORTRAIT_180: begin
                a1 = (SHORT_SIDE - 1 - x1) & 32'hFFFF;
                a2 = (LONG_SIDE - 1 - y1) & 32'hFFFF;
                col_word = (a1 << 8) + (SHORT_SIDE - 1 - x2);
                y1 = LONG_SIDE - 1 - y2;
                y2 = a2;
            end
            ORIENT_LANDSCAPE: begin
                a1 = (SHORT_SIDE - 1 - y1) & 32'hFFFF;
                col_word = (a1 << 8) + (SHORT_SIDE - 1 - y2);
                y1 = x1;
                y2 = x2;
            end
            ORIENT_LANDSCAPE_180: begin
                a2 = (LONG_SIDE - 1 - x1) & 32'hFFFF;
                col_word = (y2 << 8) + y1;
                y1 = LONG_SIDE - 1 - x2;
                y2 = a2;
            end
            default: begin
                col_word = (x2 << 8) + x1;
            end
        endcase
        y1 = y1 + 2;
        y2 = y2 + 2;
        expected_words.push_back('{KIND_CMD, {24'd0, CMD_CASET}, 1'b0});
        expected_words.push_back('{KIND_DATA, {16'd0, col_word[15:0]}, 1'b0});
        expected_words.push_back('{KIND_CMD, {24'd0, CMD_RASET}, 1'b0});
        expected_words.push_back('{KIND_DATA, {16'd0, y1[15:0]}, 1'b0});
        expected_words.push_back('{KIND_DATA, {16'd0, y2[15:0]}, 1'b0});
        expected_words.push_back('{KIND_CMD, {24'd0, CMD_RAMWR}, 1'b0});
        // Two pixels per word, leftmost pixel in the high half
        for (r = 0; r < 8; r++) begin
            for (p = 0; p < 4; p++) begin
                c0 = glyph[8 * r + 7 - 2 * p] ? ink_reg : paper_reg;
                c1 = glyph[8 * r + 6 - 2 * p] ? ink_reg : paper_reg;
                expected_words.push_back('{KIND_PIXEL, {c0, c1}, (r == 7 && p == 3)});
            end
        end
    endtask

    // Move the cursor for one character and queue any cell it draws
    task automatic predict_cursor_move(input logic [7:0] code, input logic [63:0] glyph);
        int unsigned cols, rows, tw, lin;
        cols = width_reg / GLYPH_SIZE;
        rows = height_reg / GLYPH_SIZE;
        tw   = (tab_reg == 0) ? 1 : tab_reg;
        if (cols == 0) cols = 1;
        if (rows == 0) rows = 1;
        lin = cursor_row * cols + cursor_col;
        if (code < 8'd32) begin
            case (code)
                CH_BS: begin
                    // Nothing happens at the start of a line
                    if (lin % cols > 0) begin
                        lin = lin - 1;
                        queue_cell_words(lin / cols, lin % cols, glyph);
                    end
                end
                CH_FF:  lin = 0;
                CH_LF: begin
                    lin = lin + cols;
                    lin = lin - lin % cols;
                end
                CH_CR:  lin = lin - lin % cols;
                CH_TAB: begin
                    lin = lin + tw - ((lin % cols) % tw);
                    if (lin % cols < tw) lin = lin - lin % cols;
                end
                CH_VT:  lin = lin + cols;
                default: ;
            endcase
        end else begin
            queue_cell_words(lin / cols, lin % cols, glyph);
            lin = lin + 1;
        end
        // Wrap to home past the last cell
        if (lin >= cols * rows) lin = 0;
        cursor_row = 5'((lin / cols) & 32'h1F);
        cursor_col = 5'((lin % cols) & 32'h1F);
    endtask

    always @(posedge aclk) begin
        panel_word_t w;
        if (!aresetn) begin
            orient_reg = RST_ORIENT;
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            tab_reg    = RST_TAB;
            ink_reg    = RST_INK;
            paper_reg  = RST_PAPER;
            cursor_row = '0;
            cursor_col = '0;
            fail_count = 0;
            expected_words.delete();
        end else begin
            // Mirror register writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ORIENT: orient_reg = cfg_wdata[1:0];
                    REG_WIDTH:  width_reg  = cfg_wdata[7:0];
                    REG_HEIGHT: height_reg = cfg_wdata[7:0];
                    REG_TAB:    tab_reg    = cfg_wdata[5:0];
                    REG_INK:    ink_reg    = cfg_wdata;
                    REG_PAPER:  paper_reg  = cfg_wdata;
                    default: ;
                endcase
            end
            // Predict on every input transfer
            if (s_tvalid && s_tready) predict_cursor_move(s_tdata[7:0], s_tdata[71:8]);
            // Compare every output transfer with the oldest pending word
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual kind %0d value %h last %b",
                             $time, m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    if (m_tuser !== w.kind) begin
                        $display("%0t: word_kind expected %0d actual %0d",
                                 $time, w.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== w.value) begin
                        $display("%0t: word_value expected %h actual %h",
                                 $time, w.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== w.last) begin
                        $display("%0t: last_word expected %b actual %b",
                                 $time, w.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        // Publish the number of words still owed
        pending = expected_words.size();
    end

endmodule

@@ tb/text_console_glyph_writer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_writer_test
// Drives characters with random glyphs into the text console under a series
// of screen settings, with random idle gaps on both channels and one long
// output stall. A checker beside the block predicts and compares the words.
// ----------------------------------------------------------------------------
module text_console_glyph_writer_test
    import tcgw_pkg::*;
();

    localparam int DRAIN_CYCLES  = 100;   // covers a tab item's cursor update
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 15;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [7:0] char_code, [71:8] glyph_rows
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [31:0] word_value
    logic [KIND_W-1:0]     m_tuser;          // [1:0] word_kind
    logic                  m_tlast;          // last_word
    int                    fail_count;
    int                    pending;

    // Idle pattern state per side: 0 sender, 1 receiver
    int  idle_left[2] = '{0, 0};
    bit  idle_off[2]  = '{0, 0};
    bit  hold_request = 1'b0;
    int  quiet_cycles = 0;

    text_console_glyph_writer dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

    text_console_glyph_writer_checker u_checker (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .fail_count, .pending
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Gap before the next transfer; alternate busy stretches and random idling
    function automatic int draw_gap(input int side);
        if (idle_left[side] == 0) begin
            idle_off[side]  = ($urandom_range(0, 3) == 0);
            idle_left[side] = $urandom_range(5, 20);
        end
        idle_left[side]--;
        return idle_off[side] ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send_item(input logic [7:0] code, input logic [63:0] glyph);
        int gap;
        gap = draw_gap(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {glyph, code};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_glyph(input logic [7:0] code);
        send_item(code, {$urandom, $urandom});
    endtask

    // Drop valid, wait for all words, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [1:0] orient, input logic [7:0] width,
                                  input logic [7:0] height, input logic [5:0] tab,
                                  input logic [15:0] ink, input logic [15:0] paper);
        logic [CFG_DATA_W-1:0] vals[6];
        logic [CFG_ADDR_W-1:0] regs[6];
        int i;
        vals = '{16'(orient), 16'(width), 16'(height), 16'(tab), ink, paper};
        regs = '{REG_ORIENT, REG_WIDTH, REG_HEIGHT, REG_TAB, REG_INK, REG_PAPER};
        for (i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly printable text, some cursor controls, a little unknown control
    function automatic logic [7:0] random_code();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return 8'($urandom_range(32, 255));
        if (sel < 95) begin
            case ($urandom_range(0, 5))
                0: return CH_BS;
                1: return CH_TAB;
                2: return CH_LF;
                3: return CH_VT;
                4: return CH_FF;
                default: return CH_CR;
            endcase
        end
        return 8'($urandom_range(0, 31));
    endfunction

    // Output side: random gaps plus one long hold-off on request
    task automatic run_receiver();
        int hold;
        forever begin
            hold = draw_gap(1);
            if (hold_request) begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    endtask

    initial begin
        int ph, n;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            run_receiver();
        join_none
        @(posedge aclk);

        // Reset settings: every control code and glyph extremes
        send_item(CH_FF, '0);
        send_item(8'h41, '1);
        send_item(8'hFF, '0);
        send_item(8'h20, 64'hAA55_AA55_AA55_AA55);
        send_item(CH_BS, 64'h0000_0000_0000_0000);
        send_item(CH_CR, '0);
        send_item(CH_BS, '1);                    // at line start: no draw
        send_item(CH_TAB, '0);
        send_item(CH_TAB, '0);
        send_item(CH_LF, '0);
        send_item(CH_VT, '0);
        send_item(8'd0, '1);                     // unknown control codes
        send_item(8'd31, '1);
        send_item(8'h7F, 64'h8142_2418_1824_4281);
        wait_idle();

        // Largest screen, last orientation, zero tab width
        apply_settings(ORIENT_LANDSCAPE_180, 8'd255, 8'd255, 6'd0, 16'hFFFF, 16'h0000);
        send_item(CH_FF, '0);
        send_item(8'h42, 64'h0123_4567_89AB_CDEF);
        send_item(CH_TAB, '0);
        send_item(8'h43, 64'hFEDC_BA98_7654_3210);
        wait_idle();

        // Narrow screen below one cell, tab stop of 32
        apply_settings(ORIENT_PORTRAIT_180, 8'd4, 8'd4, 6'd32, 16'h0000, 16'hFFFF);
        send_item(8'h44, '1);
        send_item(CH_TAB, '0);
        send_item(CH_LF, '0);
        wait_idle();

        // Two cells, one row: wrap to home
        apply_settings(ORIENT_LANDSCAPE, 8'd16, 8'd8, 6'd1, 16'h1234, 16'hFEDC);
        send_item(8'h45, 64'hF0F0_F0F0_0F0F_0F0F);
        send_item(8'h46, 64'h0F0F_0F0F_F0F0_F0F0);
        send_item(8'h47, '1);
        send_item(CH_BS, '0);
        wait_idle();

        // Random settings and mostly printable text
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            apply_settings(2'($urandom_range(0, 3)),
                           8'($urandom_range(0, 1) ? $urandom_range(8, 48)
                                                   : $urandom_range(8, 255)),
                           8'($urandom_range(0, 1) ? $urandom_range(8, 48)
                                                   : $urandom_range(8, 255)),
                           6'($urandom_range(1, 32)),
                           16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
            if (ph == 0) hold_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) send_random_glyph(random_code());
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
